// ----- rtl/lpht_pkg.sv -----
// Shared constants, codes and types for the linear-probing hash table.
// No dependencies; used by lpht_slot_store and linear_probe_hash_table.
package lpht_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 32;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic              rd;
    logic              wr_new;
    logic              wr_val;
    logic [SLOT_W-1:0] addr;
  } store_req_t;

endpackage

// ----- rtl/linear_probe_hash_table.sv -----
// Linear-probing hash table: top level with probe sequencer and result register.
// Depends on lpht_pkg and lpht_slot_store.
//
// Holds 64 slots of 64-bit key and 32-bit value. Each request beat is a lookup
// or an insert (in_tuser) and yields exactly one result beat. Probing starts at
// the low six key bits and walks one slot at a time with wraparound. Every probe
// is a memory read, then a compare, and a request probes 1 to 64 slots. A refused
// insert (zero value or full table) goes straight to the result without probing.
// The block takes one request at a time; a finished result waits in the output
// register until taken. After reset the table is empty and ready at once.
module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [63:0] key, [95:64] value
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] found_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic                           op_r, op_nxt;
  logic [lpht_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [lpht_pkg::VAL_W-1:0]     val_r, val_nxt;
  logic [lpht_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic [lpht_pkg::SLOT_W-1:0]    probe_r, probe_nxt;
  logic [lpht_pkg::CNT_W-1:0]     count_r, count_nxt;
  lpht_pkg::status_t              res_status_r, res_status_nxt;
  logic [lpht_pkg::VAL_W-1:0]     res_found_r, res_found_nxt;
  logic                           out_valid_r, out_valid_nxt;
  lpht_pkg::status_t              out_status_r, out_status_nxt;
  logic [lpht_pkg::VAL_W-1:0]     out_found_r, out_found_nxt;

  lpht_pkg::store_req_t           req;
  logic                           used_q;
  logic [lpht_pkg::KEY_W-1:0]     key_q;
  logic [lpht_pkg::VAL_W-1:0]     value_q;

  logic in_fire;
  logic can_out;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign can_out    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_found_r;
  assign out_tuser  = out_status_r;

  lpht_slot_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .wr_key   (key_r),
    .wr_value (val_r),
    .used_q   (used_q),
    .key_q    (key_q),
    .value_q  (value_q)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    probe_nxt      = probe_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    req            = '0;
    req.addr       = slot_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt        = in_tuser[0];
          key_nxt       = in_tdata[63:0];
          val_nxt       = in_tdata[95:64];
          slot_nxt      = in_tdata[lpht_pkg::SLOT_W-1:0];
          probe_nxt     = '0;
          res_found_nxt = '0;
          if (in_tuser[0] == lpht_pkg::OP_INSERT && in_tdata[95:64] == '0) begin
            res_status_nxt = lpht_pkg::ST_INVALID;
            state_nxt      = S_RESP;
          end else if (in_tuser[0] == lpht_pkg::OP_INSERT &&
                       count_r == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE)) begin
            res_status_nxt = lpht_pkg::ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        req.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!used_q) begin
          if (op_r == lpht_pkg::OP_INSERT) begin
            req.wr_new     = 1'b1;
            count_nxt      = count_r + lpht_pkg::CNT_W'(1);
            res_status_nxt = lpht_pkg::ST_OK;
          end else begin
            res_status_nxt = lpht_pkg::ST_MISS;
          end
          state_nxt = S_RESP;
        end else if (key_q == key_r) begin
          if (op_r == lpht_pkg::OP_INSERT) begin
            req.wr_val = 1'b1;
          end else begin
            res_found_nxt = value_q;
          end
          res_status_nxt = lpht_pkg::ST_OK;
          state_nxt      = S_RESP;
        end else if (probe_r == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1)) begin
          res_status_nxt = (op_r == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                         : lpht_pkg::ST_MISS;
          state_nxt      = S_RESP;
        end else begin
          slot_nxt  = (slot_r == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1)) ? '0
                      : slot_r + lpht_pkg::SLOT_W'(1);
          probe_nxt = probe_r + lpht_pkg::SLOT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_RESP: begin
        if (can_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    probe_r      <= probe_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

endmodule

// ----- rtl/lpht_slot_store.sv -----
// Slot storage: occupied bits in flops, key and value memories with
// registered read. Depends on lpht_pkg.
module lpht_slot_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lpht_pkg::store_req_t      req,
  input  logic [lpht_pkg::KEY_W-1:0] wr_key,
  input  logic [lpht_pkg::VAL_W-1:0] wr_value,
  output logic                      used_q,
  output logic [lpht_pkg::KEY_W-1:0] key_q,
  output logic [lpht_pkg::VAL_W-1:0] value_q
);

  logic [lpht_pkg::TABLE_SIZE-1:0] used_r;
  logic [lpht_pkg::KEY_W-1:0]      key_mem [lpht_pkg::TABLE_SIZE];
  logic [lpht_pkg::VAL_W-1:0]      val_mem [lpht_pkg::TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      used_q <= 1'b0;
    end else begin
      if (req.wr_new) begin
        used_r[req.addr] <= 1'b1;
      end
      if (req.rd) begin
        used_q <= used_r[req.addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_new) begin
      key_mem[req.addr] <= wr_key;
    end
    if (req.rd) begin
      key_q <= key_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_new || req.wr_val) begin
      val_mem[req.addr] <= wr_value;
    end
    if (req.rd) begin
      value_q <= val_mem[req.addr];
    end
  end

endmodule

// ----- dv/lpht_checker.sv -----
// Checker for linear_probe_hash_table: keeps its own copy of the slot table and
// predicts one reply per accepted request beat. It compares replies in order.
// Depends on lpht_pkg; instantiated by linear_probe_hash_table_tb beside the DUT.
module lpht_checker
  import lpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // [63:0] key, [95:64] value
  input  logic [0:0]  in_tuser,   // [0] operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] found_value
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] found_value;
  } reply_t;

  bit               tbl_used [TABLE_SIZE];
  logic [KEY_W-1:0] tbl_key  [TABLE_SIZE];
  logic [VAL_W-1:0] tbl_val  [TABLE_SIZE];
  int unsigned      tbl_count;
  reply_t           owed_replies [$];
  reply_t           want;

  function automatic reply_t run_request(input logic op, input logic [KEY_W-1:0] key,
                                         input logic [VAL_W-1:0] val);
    reply_t      r;
    int unsigned slot;
    int          p;
    r.status      = ST_MISS;
    r.found_value = '0;
    slot          = key % TABLE_SIZE;
    if (op == OP_LOOKUP) begin
      for (p = 0; p < TABLE_SIZE; p++) begin
        if (!tbl_used[slot]) break;
        if (tbl_key[slot] == key) begin
          r.status      = ST_OK;
          r.found_value = tbl_val[slot];
          break;
        end
        slot = (slot + 1) % TABLE_SIZE;
      end
    end else if (val == '0) begin
      r.status = ST_INVALID;
    end else if (tbl_count >= TABLE_SIZE) begin
      r.status = ST_FULL;
    end else begin
      r.status = ST_FULL;
      for (p = 0; p < TABLE_SIZE; p++) begin
        if (!tbl_used[slot]) begin
          tbl_used[slot] = 1'b1;
          tbl_key[slot]  = key;
          tbl_val[slot]  = val;
          tbl_count++;
          r.status = ST_OK;
          break;
        end
        if (tbl_key[slot] == key) begin
          tbl_val[slot] = val;
          r.status      = ST_OK;
          break;
        end
        slot = (slot + 1) % TABLE_SIZE;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      tbl_count  = 0;
      fail_count = 0;
      owed_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_replies.size() == 0) begin
          $error("reply beat with no request outstanding: status %0d found_value 0x%08h",
                 out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata !== want.found_value) begin
            $error("found_value: expected 0x%08h, actual 0x%08h", want.found_value, out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        owed_replies.push_back(run_request(in_tuser[0], in_tdata[63:0], in_tdata[95:64]));
    end
    replies_owed = owed_replies.size();
  end

endmodule

// ----- dv/linear_probe_hash_table_tb.sv -----
// Testbench top for linear_probe_hash_table: clock, reset, request and reply traffic.
// Directed lookups and inserts, then random ones that fill the table; lpht_checker
// (and lpht_pkg) judges the replies, this module gives the verdict.
module linear_probe_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata   = '0;   // [63:0] key, [95:64] value
  logic [0:0]  in_tuser   = '0;   // [0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] found_value
  logic [1:0]  out_tuser;         // [1:0] status

  int               fail_count;
  int               replies_owed;
  int unsigned      beats_sent = 0;
  logic [KEY_W-1:0] key_pool [$];

  always #5 clk = ~clk;

  linear_probe_hash_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lpht_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    while (!(beats_sent >= 500 && beats_sent < 700) && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, key};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (op == OP_INSERT && val != '0) key_pool.push_back(key);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int unsigned      r;
    r = $urandom_range(99);
    if (r < 70 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      k = {$urandom, $urandom};
      // crowd a few home slots around the wrap point
      if (r < 85) k[5:0] = 6'(62 + $urandom_range(3));
    end
    return k;
  endfunction

  initial begin
    logic [VAL_W-1:0] val;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_LOOKUP, 64'd0, 32'd0);
    send_request(OP_INSERT, 64'd0, 32'd0);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_LOOKUP, '1, 32'h1234_5678);
    send_request(OP_INSERT, 64'd0, 32'd5);
    send_request(OP_INSERT, 64'd64, 32'd6);
    send_request(OP_INSERT, 64'd127, 32'd7);
    send_request(OP_LOOKUP, 64'd127, 32'd0);
    send_request(OP_INSERT, 64'd0, '1);
    send_request(OP_LOOKUP, 64'd0, 32'd0);
    send_request(OP_LOOKUP, 64'd128, 32'd0);
    send_request(OP_INSERT, 64'd64, 32'd0);
    send_request(OP_LOOKUP, 64'd64, '1);
    send_request(OP_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_request(OP_LOOKUP, 64'h8000_0000_0000_0000, '1);
    send_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    send_request(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_request(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
    send_request(OP_LOOKUP, 64'h5555_5555_5555_5555, 32'd0);
    send_request(OP_LOOKUP, 64'h0000_0001_0000_0000, 32'd0);

    repeat (1200) begin
      if ($urandom_range(99) < 8) begin
        val = '0;
      end else begin
        val = $urandom;
        if (val == '0) val = 32'd1;
      end
      send_request(1'($urandom_range(1)), pick_key(), val);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned cycle_cnt;
    bit          held;
    cycle_cnt = 0;
    held      = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (!held && beats_sent >= 300) begin
        // hold off the reply side so the request side backs up
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (cycle_cnt >= 3000 && cycle_cnt < 6000) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
